### sv/nsit_pkg.sv
// ----------------------------------------------------------------------------
// nsit_pkg: shared types and helpers of the top-N sorted insertion table
// Holds the operation codes, the stored entry layout, the result layout and
// the tag normalization function.
// ----------------------------------------------------------------------------
package nsit_pkg;

	localparam int SLOTS_DEF = 8;
	localparam int TAG_CHARS = 15;
	localparam int TAG_BITS  = 8 * TAG_CHARS;

	typedef enum logic [1:0] {
		OP_SUBMIT = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_READ   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef struct packed {
		logic signed [31:0] score;
		logic [63:0]        name_lo;
		logic [55:0]        name_hi;
	} entry_t;

	typedef struct packed {
		logic               accepted;
		logic [2:0]         slot;
		logic signed [31:0] slot_score;
		logic [63:0]        slot_name_lo;
		logic [55:0]        slot_name_hi;
		logic [3:0]         filled;
	} result_t;

	// Every byte from the first zero byte on is cleared. Byte 0 sits in the low bits.
	function automatic logic [TAG_BITS-1:0] norm_tag(input logic [TAG_BITS-1:0] raw);
		logic [TAG_BITS-1:0] outv;
		logic                keep;
		outv = '0;
		keep = 1'b1;
		for (int i = 0; i < TAG_CHARS; i++) begin
			keep = keep & (raw[8*i +: 8] != 8'd0);
			outv[8*i +: 8] = keep ? raw[8*i +: 8] : 8'd0;
		end
		return outv;
	endfunction

endpackage

### sv/nsit_req_if.sv
// ----------------------------------------------------------------------------
// nsit_req_if: request channel of the top-N sorted insertion table
// Valid/ready channel carrying one operation and its operands.
// ----------------------------------------------------------------------------
interface nsit_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic signed [31:0] score;
	logic [63:0]        name_lo;
	logic [55:0]        name_hi;
	logic [2:0]         read_slot;

	modport source (output valid, output op, output score, output name_lo,
		output name_hi, output read_slot, input ready);
	modport sink (input valid, input op, input score, input name_lo,
		input name_hi, input read_slot, output ready);
endinterface

### sv/nsit_rsp_if.sv
// ----------------------------------------------------------------------------
// nsit_rsp_if: response channel of the top-N sorted insertion table
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface nsit_rsp_if;
	logic               valid;
	logic               ready;
	logic               accepted;
	logic [2:0]         slot;
	logic signed [31:0] slot_score;
	logic [63:0]        slot_name_lo;
	logic [55:0]        slot_name_hi;
	logic [3:0]         filled;

	modport source (output valid, output accepted, output slot, output slot_score,
		output slot_name_lo, output slot_name_hi, output filled, input ready);
	modport sink (input valid, input accepted, input slot, input slot_score,
		input slot_name_lo, input slot_name_hi, input filled, output ready);
endinterface

### sv/nsit_mem.sv
// ----------------------------------------------------------------------------
// nsit_mem: entry store of the top-N sorted insertion table
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nsit_mem #(
	parameter int SLOTS = nsit_pkg::SLOTS_DEF,
	parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IW-1:0]    waddr,
	input  nsit_pkg::entry_t wdata,
	input  logic             re,
	input  logic [IW-1:0]    raddr,
	output nsit_pkg::entry_t rdata
);
	import nsit_pkg::*;

	entry_t mem [SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/nsit_ctrl.sv
// ----------------------------------------------------------------------------
// nsit_ctrl: sequencer of the top-N sorted insertion table
// Walks the store from the fill mark upward, moving lower entries down one
// place until the insertion point is found, and serves reads and clears.
// ----------------------------------------------------------------------------
module nsit_ctrl #(
	parameter int SLOTS = nsit_pkg::SLOTS_DEF,
	parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
	parameter int CW    = $clog2(SLOTS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	nsit_req_if.sink          req,
	output nsit_pkg::result_t res,
	output logic              res_valid,
	input  logic              res_take,
	output logic              mem_we,
	output logic [IW-1:0]     mem_waddr,
	output nsit_pkg::entry_t  mem_wdata,
	output logic              mem_re,
	output logic [IW-1:0]     mem_raddr,
	input  nsit_pkg::entry_t  mem_rdata
);
	import nsit_pkg::*;

	localparam int RW = (IW > 3) ? IW : 3;
	localparam int SW = (CW > 3) ? CW : 3;
	localparam int FW = (CW > 4) ? CW : 4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_CMP,
		S_INSERT,
		S_RDDATA,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       fill_q;
	logic [CW-1:0]       k_q;
	entry_t              new_q;
	result_t             res_q;

	logic                acc;
	logic                rd_hit;
	logic [RW-1:0]       rs_ext;
	logic [CW-1:0]       km1;
	logic                k_in;
	logic                lower;
	logic [SW-1:0]       k_ext;
	logic [FW-1:0]       fill_ext;
	logic [TAG_BITS-1:0] tag_n;

	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;
	assign rs_ext    = RW'(req.read_slot);
	// Slots at or above the fill mark are empty and read as zero.
	assign rd_hit    = ({{CW{1'b0}}, req.read_slot} < {3'b000, fill_q});
	assign km1       = k_q - CW'(1);
	assign k_in      = (k_q < CW'(SLOTS));
	assign lower     = (mem_rdata.score < new_q.score);
	assign k_ext     = SW'(k_q);
	assign fill_ext  = FW'(fill_q);
	assign tag_n     = norm_tag({req.name_hi, req.name_lo});

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = km1[IW-1:0];
		mem_we    = 1'b0;
		mem_waddr = k_q[IW-1:0];
		mem_wdata = new_q;
		case (state_q)
			S_IDLE: begin
				mem_re    = acc && (op_t'(req.op) == OP_READ) && rd_hit;
				mem_raddr = rs_ext[IW-1:0];
			end
			S_WALK: begin
				mem_re = (k_q != '0);
			end
			S_CMP: begin
				// Entry above is lower than the new score: move it down one place.
				mem_we    = lower && k_in;
				mem_wdata = mem_rdata;
			end
			S_INSERT: begin
				mem_we = k_in;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res        = res_q;
		res.filled = fill_ext[3:0];
	end

	assign res_valid = (state_q == S_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						res_q         <= '0;
						new_q.score   <= req.score;
						new_q.name_lo <= tag_n[63:0];
						new_q.name_hi <= tag_n[TAG_BITS-1:64];
						k_q           <= fill_q;
						case (op_t'(req.op))
							OP_SUBMIT: begin
								state_q <= (req.score > 0) ? S_WALK : S_DONE;
							end
							OP_CLEAR: begin
								fill_q  <= '0;
								state_q <= S_DONE;
							end
							OP_READ: begin
								state_q <= rd_hit ? S_RDDATA : S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_WALK: begin
					state_q <= (k_q == '0) ? S_INSERT : S_CMP;
				end
				S_CMP: begin
					if (lower) begin
						k_q     <= km1;
						state_q <= S_WALK;
					end else begin
						state_q <= S_INSERT;
					end
				end
				S_INSERT: begin
					if (k_in) begin
						res_q.accepted <= 1'b1;
						res_q.slot     <= k_ext[2:0];
						if (fill_q < CW'(SLOTS)) begin
							fill_q <= fill_q + CW'(1);
						end
					end
					state_q <= S_DONE;
				end
				S_RDDATA: begin
					res_q.slot_score   <= mem_rdata.score;
					res_q.slot_name_lo <= mem_rdata.name_lo;
					res_q.slot_name_hi <= mem_rdata.name_hi;
					state_q            <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(SLOTS))
		else $error("fill count exceeds table depth");

	a_walk_below_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK || state_q == S_CMP || state_q == S_INSERT) |-> k_q <= fill_q)
		else $error("walk position above fill mark");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> k_in && !mem_re)
		else $error("store write out of range or overlapping a read");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INSERT && k_in && fill_q < CW'(SLOTS)) |=> fill_q == $past(fill_q) + CW'(1))
		else $error("accepted insert did not raise fill count");

	a_accept_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_q.accepted) |-> fill_q != '0)
		else $error("accepted submit with empty table");

endmodule

### sv/top_n_sorted_insert_table_top.sv
// ----------------------------------------------------------------------------
// top_n_sorted_insert_table_top: top-N score table with tags
// Keeps entries in descending score order in a one-port-read store.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the req channel and each one yields exactly one result
// on the rsp channel; a transaction completes when valid and ready are high.
// A submit is placed after every stored entry with an equal or higher score;
// lower entries move down one slot and the last falls off a full table.
// The sequencer walks the store from the fill mark upward; for each entry
// it compares, it first reads the entry, then compares and moves it. A
// submit stops at an equal or higher score or when it reaches slot 0; a
// read of an occupied slot fetches the entry from the store. Submits with
// a score that is not positive are rejected without a walk. One request is
// in work at a time; req.ready rises as the result register loads, so the
// next request can be taken in the following cycle.
// Results sit in an output register, so the next request is taken while a
// result waits; a stalled receiver holds the sequencer once it has its next
// result ready. Reset empties the table at once.
// ----------------------------------------------------------------------------
module top_n_sorted_insert_table_top #(
	parameter int SLOTS = nsit_pkg::SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	nsit_req_if.sink   req,
	nsit_rsp_if.source rsp
);
	import nsit_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	result_t       res;
	logic          res_valid;
	logic          out_free;
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic          mem_re;
	logic [IW-1:0] mem_raddr;
	entry_t        mem_rdata;
	result_t       rsp_q;
	logic          rsp_valid_q;

	nsit_ctrl #(.SLOTS(SLOTS), .IW(IW), .CW(CW)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res       (res),
		.res_valid (res_valid),
		.res_take  (out_free),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	nsit_mem #(.SLOTS(SLOTS), .IW(IW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign out_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= res_valid;
			if (res_valid) begin
				rsp_q <= res;
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.accepted     = rsp_q.accepted;
	assign rsp.slot         = rsp_q.slot;
	assign rsp.slot_score   = rsp_q.slot_score;
	assign rsp.slot_name_lo = rsp_q.slot_name_lo;
	assign rsp.slot_name_hi = rsp_q.slot_name_hi;
	assign rsp.filled       = rsp_q.filled;

endmodule
